// ===== sv/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue core.
// Used by spq_front, spq_back and sorted_priority_queue_core; no dependencies.

package spq_pkg;

   localparam int DATA_BITS   = 32;
   localparam int PRIO_W      = 8;   // priority field width on the ports
   localparam int OCC_BITS    = 4;
   localparam int QUEUE_DEPTH = 2;   // command queue between front and back
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      op_type                 op;
      logic [DATA_BITS-1:0]   data;
      logic [PRIO_W-1:0]      prio;
   } cmd_type;

   typedef struct packed {
      status_type             status;
      logic [DATA_BITS-1:0]   data;
      logic [PRIO_W-1:0]      prio;
      logic [OCC_BITS-1:0]    occupancy;
   } rsp_type;

endpackage

// ===== sv/spq_front.sv =====
// Front end: accept request items, decode them into commands and hold them
// in a short queue for the back end. Depends on spq_pkg.

module spq_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [0:0]        req_tuser,
   input  logic [39:0]       req_tdata,
   output logic              cmd_valid,
   output spq_pkg::cmd_type  cmd,
   input  logic              cmd_pop
);

   localparam int CNT_BITS = $clog2(spq_pkg::QUEUE_DEPTH + 1);

   spq_pkg::cmd_type                slot_ff [spq_pkg::QUEUE_DEPTH];
   logic [spq_pkg::QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [spq_pkg::QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]             count_ff, count_in;
   spq_pkg::cmd_type                decoded;
   logic                            push, pop;

   // Classify the incoming item.
   always_comb begin
      decoded.op   = spq_pkg::op_type'(req_tuser);
      decoded.data = req_tdata[31:0];
      decoded.prio = req_tdata[39:32];
   end

   assign req_tready = (count_ff != CNT_BITS'(spq_pkg::QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (count_ff != '0);
   assign pop        = cmd_pop && cmd_valid;
   assign cmd        = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == spq_pkg::QPTR_BITS'(spq_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == spq_pkg::QPTR_BITS'(spq_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ===== sv/spq_back.sv =====
// Back end: row of sorted entry cells with parallel compare-and-shift, plus
// the result register. Depends on spq_pkg.

module spq_back #(
   parameter int DEPTH     = 8,
   parameter int PRIO_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  spq_pkg::cmd_type  cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output spq_pkg::rsp_type  rsp
);

   localparam int CW = $clog2(DEPTH + 1);

   logic [spq_pkg::DATA_BITS-1:0] ent_data_ff [DEPTH];
   logic [spq_pkg::DATA_BITS-1:0] ent_data_in [DEPTH];
   logic [PRIO_BITS-1:0]          ent_prio_ff [DEPTH];
   logic [PRIO_BITS-1:0]          ent_prio_in [DEPTH];
   logic [CW-1:0]                 count_ff, count_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   spq_pkg::rsp_type              rsp_ff, rsp_in;
   logic [DEPTH-1:0]              ge;
   logic [PRIO_BITS-1:0]          new_prio;
   logic [31:0]                   prio_in_ext, head_prio_ext, count_ext;
   logic                          fire;

   assign fire      = cmd_valid && (!rsp_valid_ff || rsp_ready);
   assign cmd_pop   = fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Keep only the low PRIO_BITS of the port priority.
   assign prio_in_ext   = 32'(cmd.prio);
   assign new_prio      = prio_in_ext[PRIO_BITS-1:0];
   assign head_prio_ext = 32'(ent_prio_ff[0]);
   assign count_ext     = 32'(count_in);

   // Each occupied cell flags whether it stays ahead of the new entry.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ge[i] = (CW'(i) < count_ff) && (ent_prio_ff[i] >= new_prio);
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ent_data_in[i] = ent_data_ff[i];
         ent_prio_in[i] = ent_prio_ff[i];
      end
      count_in         = count_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_in           = rsp_ff;
      if (fire) begin
         rsp_valid_in   = 1'b1;
         rsp_in.status  = spq_pkg::ST_DONE;
         rsp_in.data    = '0;
         rsp_in.prio    = '0;
         case (cmd.op)
            spq_pkg::OP_INSERT: begin
               if (count_ff == CW'(DEPTH)) begin
                  rsp_in.status = spq_pkg::ST_FULL;
               end else begin
                  // Cell 0 takes the new entry unless it stays.
                  if (!ge[0]) begin
                     ent_data_in[0] = cmd.data;
                     ent_prio_in[0] = new_prio;
                  end
                  for (int i = 1; i < DEPTH; i++) begin
                     if (!ge[i]) begin
                        if (ge[i-1]) begin
                           ent_data_in[i] = cmd.data;
                           ent_prio_in[i] = new_prio;
                        end else begin
                           ent_data_in[i] = ent_data_ff[i-1];
                           ent_prio_in[i] = ent_prio_ff[i-1];
                        end
                     end
                  end
                  count_in = count_ff + 1'b1;
               end
            end
            spq_pkg::OP_REMOVE: begin
               if (count_ff == '0) begin
                  rsp_in.status = spq_pkg::ST_EMPTY;
               end else begin
                  rsp_in.data = ent_data_ff[0];
                  rsp_in.prio = head_prio_ext[spq_pkg::PRIO_W-1:0];
                  // Advance every entry one cell toward the head.
                  for (int i = 0; i < DEPTH - 1; i++) begin
                     ent_data_in[i] = ent_data_ff[i+1];
                     ent_prio_in[i] = ent_prio_ff[i+1];
                  end
                  count_in = count_ff - 1'b1;
               end
            end
            default: begin
               rsp_in.status = spq_pkg::ST_DONE;
            end
         endcase
         rsp_in.occupancy = count_ext[spq_pkg::OCC_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      for (int i = 0; i < DEPTH; i++) begin
         ent_data_ff[i] <= ent_data_in[i];
         ent_prio_ff[i] <= ent_prio_in[i];
      end
   end

endmodule

// ===== sv/sorted_priority_queue_core.sv =====
// Sorted priority queue core: top level joining the front end and the cell row.
// Depends on spq_pkg, spq_front and spq_back.
//
// Usage:
//   Request channel (req_*): one item per insert or remove. tuser carries the
//   command (0 insert, 1 remove the highest-priority entry); tdata carries the
//   data word and its priority. Higher priority leaves first; equal
//   priorities leave in arrival order.
//   Response channel (rsp_*): exactly one item per request, in request order.
//   tuser carries the status (0 done, 1 full and insert dropped, 2 empty and
//   nothing removed); tdata carries the removed word, its priority (both zero
//   unless a remove succeeded) and the occupancy after the operation.
//   An accepted request waits in the command queue; its response is registered.
//   Throughput: one item per cycle while rsp_tready stays high, set by the
//   parallel compare-and-shift across all DEPTH entry cells.
//   Reset (synchronous, active high) empties the queue and drops any queued
//   or pending response. When the receiver stalls, the response register
//   holds its item, the back end stops, and the two-entry command queue
//   fills before req_tready falls.

module sorted_priority_queue_core #(
   parameter int DEPTH     = 8,
   parameter int PRIO_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [0:0]  req_tuser,   // [0] cmd
   input  logic [39:0] req_tdata,   // [31:0] data_in, [39:32] priority_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic [47:0] rsp_tdata    // [31:0] out_data, [39:32] out_priority,
                                    // [43:40] occupancy, [47:44] zero
);

   logic              cmd_valid;
   logic              cmd_pop;
   spq_pkg::cmd_type  cmd;
   spq_pkg::rsp_type  rsp;

   // Accept and decode requests; hold them until the cell row takes them.
   spq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   // Carry out one command per cycle while the response register is free.
   spq_back #(
      .DEPTH     (DEPTH),
      .PRIO_BITS (PRIO_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // Pack the response fields, lowest bit first.
   assign rsp_tuser = rsp.status;
   assign rsp_tdata = {4'b0000, rsp.occupancy, rsp.prio, rsp.data};

endmodule

// ===== tb/sv/sorted_priority_queue_core_test.sv =====
// Self-checking testbench for sorted_priority_queue_core: drives insert and remove
// items with random gaps and stalls, and checks every response against a local queue model.
// Depends on spq_pkg and the sorted_priority_queue_core RTL.

module sorted_priority_queue_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = 8;
   localparam int PRIO_BITS   = 8;
   localparam logic [spq_pkg::PRIO_W-1:0] PRIO_MASK =
      spq_pkg::PRIO_W'((64'd1 << PRIO_BITS) - 64'd1);
   localparam int RANDOM_OPS  = 1630;
   localparam int SETTLE_CYCLES = 12;
   localparam int CYCLE_LIMIT = 200000;

   // One queue operation waiting to be driven, with its idle gap in front.
   typedef struct {
      spq_pkg::op_type               op;
      logic [spq_pkg::DATA_BITS-1:0] data;
      logic [spq_pkg::PRIO_W-1:0]    prio;
      int unsigned                   gap;
      bit                            drain;   // wait until every response is back
   } queue_op;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [0:0]  req_tuser = 1'b0;    // [0] cmd
   logic [39:0] req_tdata = '0;      // [31:0] data_in, [39:32] priority_in
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [1:0]  rsp_tuser;           // [1:0] status
   logic [47:0] rsp_tdata;           // [31:0] out_data, [39:32] out_priority,
                                     // [43:40] occupancy, [47:44] zero

   sorted_priority_queue_core #(
      .DEPTH     (DEPTH),
      .PRIO_BITS (PRIO_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Operations still to drive, and the responses the queue model predicts.
   queue_op          pending_ops[$];
   spq_pkg::rsp_type expected_rsp[$];

   // Queue model: slot 0 holds the head, i.e. the highest priority.
   logic [spq_pkg::DATA_BITS-1:0] slot_data [DEPTH];
   logic [spq_pkg::PRIO_W-1:0]    slot_prio [DEPTH];
   int                            slot_count = 0;

   int error_count = 0;
   int cycle_count = 0;

   // Apply one accepted operation to the model and queue its response.
   task automatic predict_response(input queue_op qop);
      spq_pkg::rsp_type           r;
      logic [spq_pkg::PRIO_W-1:0] p;
      int                         pos;
      r.status    = spq_pkg::ST_DONE;
      r.data      = '0;
      r.prio      = '0;
      p = qop.prio & PRIO_MASK;
      if (qop.op == spq_pkg::OP_INSERT) begin
         if (slot_count >= DEPTH) begin
            r.status = spq_pkg::ST_FULL;
         end else begin
            // place behind every entry of equal or higher priority
            pos = 0;
            while (pos < slot_count && slot_prio[pos] >= p) pos++;
            for (int i = slot_count; i > pos; i--) begin
               slot_data[i] = slot_data[i-1];
               slot_prio[i] = slot_prio[i-1];
            end
            slot_data[pos] = qop.data;
            slot_prio[pos] = p;
            slot_count++;
         end
      end else begin
         if (slot_count == 0) begin
            r.status = spq_pkg::ST_EMPTY;
         end else begin
            r.data = slot_data[0];
            r.prio = slot_prio[0];
            for (int i = 1; i < slot_count; i++) begin
               slot_data[i-1] = slot_data[i];
               slot_prio[i-1] = slot_prio[i];
            end
            slot_count--;
         end
      end
      r.occupancy = spq_pkg::OCC_BITS'(slot_count);
      expected_rsp.push_back(r);
   endtask

   task automatic add_op(input spq_pkg::op_type op,
                         input logic [spq_pkg::DATA_BITS-1:0] data,
                         input logic [spq_pkg::PRIO_W-1:0] prio, input int unsigned gap,
                         input bit drain);
      queue_op qop;
      qop.op    = op;
      qop.data  = data;
      qop.prio  = prio;
      qop.gap   = gap;
      qop.drain = drain;
      pending_ops.push_back(qop);
   endtask

   // Report one field mismatch; returns 1 when the field is wrong.
   function automatic int field_differs(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
                  act_val);
         return 1;
      end
      return 0;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: hold each item until accepted, then wait out the next gap.
   // tvalid gets exactly one nonblocking update per edge.
   // ---------------------------------------------------------------------
   queue_op     on_bus;
   queue_op     staged_op;
   bit          staged = 1'b0;
   int unsigned hold_cnt = 0;

   always @(posedge clock) begin
      logic nxt_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
         staged = 1'b0;
         hold_cnt = 0;
      end else begin
         nxt_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            predict_response(on_bus);
            nxt_valid = 1'b0;
         end
         if (!nxt_valid) begin
            // pull the next item and load its idle gap
            if (!staged && pending_ops.size() != 0) begin
               staged_op = pending_ops.pop_front();
               staged = 1'b1;
               hold_cnt = staged_op.gap;
            end
            // a drain item holds until every response has come back
            if (staged && !(staged_op.drain && expected_rsp.size() != 0)) begin
               if (hold_cnt != 0) begin
                  hold_cnt--;
               end else begin
                  on_bus = staged_op;
                  staged = 1'b0;
                  nxt_valid = 1'b1;
                  req_tuser <= staged_op.op;
                  req_tdata <= {staged_op.prio, staged_op.data};
               end
            end
         end
         req_tvalid <= nxt_valid;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: check each accepted response against the oldest prediction,
   // then hold tready low for a random stall count of 0..3, with calm stretches.
   // ---------------------------------------------------------------------
   int unsigned stall_cnt = 0;
   int unsigned calm_left = 0;

   always @(posedge clock) begin
      logic             nxt_ready;
      spq_pkg::rsp_type r;
      int               bad;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_cnt = 0;
      end else begin
         nxt_ready = rsp_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: response with none expected, actual status %0h data %0h",
                        $time, rsp_tuser, rsp_tdata);
               error_count++;
            end else begin
               r = expected_rsp.pop_front();
               bad = field_differs("status", 32'(r.status), 32'(rsp_tuser))
                   + field_differs("out_data", r.data, rsp_tdata[31:0])
                   + field_differs("out_priority", 32'(r.prio), 32'(rsp_tdata[39:32]))
                   + field_differs("occupancy", 32'(r.occupancy), 32'(rsp_tdata[43:40]))
                   + field_differs("tdata pad", 32'd0, 32'(rsp_tdata[47:44]));
               if (bad != 0) error_count++;
            end
            nxt_ready = 1'b0;
            // draw the stall for the next item
            if (calm_left != 0) begin
               calm_left--;
               stall_cnt = 0;
            end else if ($urandom_range(0, 19) == 0) begin
               calm_left = $urandom_range(20, 60);
               stall_cnt = 0;
            end else begin
               stall_cnt = $urandom_range(0, 3);
            end
         end
         if (!nxt_ready) begin
            if (stall_cnt != 0) stall_cnt--;
            else nxt_ready = 1'b1;
         end
         rsp_tready <= nxt_ready;
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run.
   // ---------------------------------------------------------------------
   initial begin
      int          made;
      int          phase_len;
      int          insert_pct;
      int          prio_mode;
      bit          calm;
      logic [7:0]  p;
      int unsigned g;
      spq_pkg::op_type op;

      // Directed: remove from empty, priority and data extremes, ties,
      // fill to full, insert into full, drain past empty.
      add_op(spq_pkg::OP_REMOVE, 32'hFFFF_FFFF, 8'hFF, 0, 1'b0);
      add_op(spq_pkg::OP_INSERT, 32'h0000_0000, 8'h00, 0, 1'b0);
      add_op(spq_pkg::OP_INSERT, 32'hFFFF_FFFF, 8'hFF, 1, 1'b0);
      add_op(spq_pkg::OP_INSERT, 32'hA5A5_A5A5, 8'h80, 0, 1'b0);
      add_op(spq_pkg::OP_INSERT, 32'h5A5A_5A5A, 8'h80, 2, 1'b0);
      add_op(spq_pkg::OP_INSERT, 32'h1234_5678, 8'h80, 0, 1'b0);
      add_op(spq_pkg::OP_INSERT, 32'h8765_4321, 8'hFF, 0, 1'b0);
      add_op(spq_pkg::OP_INSERT, 32'h0F0F_0F0F, 8'h00, 3, 1'b0);
      add_op(spq_pkg::OP_INSERT, 32'hF0F0_F0F0, 8'h01, 0, 1'b0);
      add_op(spq_pkg::OP_INSERT, 32'hDEAD_BEEF, 8'hFF, 0, 1'b0);
      for (int i = 0; i < 9; i++) begin
         add_op(spq_pkg::OP_REMOVE, 32'hFFFF_FFFF, 8'hFF, i % 2, 1'b0);
      end

      // Random: phases that lean toward filling, churning or emptying,
      // each with its own priority spread and idle pattern.
      made = 0;
      while (made < RANDOM_OPS) begin
         phase_len  = $urandom_range(30, 100);
         case ($urandom_range(0, 2))
            0: insert_pct = 75;
            1: insert_pct = 50;
            default: insert_pct = 25;
         endcase
         prio_mode = $urandom_range(0, 2);
         calm = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < phase_len && made < RANDOM_OPS; i++) begin
            case (prio_mode)
               0: p = 8'($urandom_range(0, 3));          // many ties
               1: p = 8'($urandom);
               default: begin
                  case ($urandom_range(0, 3))
                     0: p = 8'h00;
                     1: p = 8'h01;
                     2: p = 8'hFE;
                     default: p = 8'hFF;
                  endcase
               end
            endcase
            g = calm ? 0 : $urandom_range(0, 3);
            op = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::OP_INSERT
                                                      : spq_pkg::OP_REMOVE;
            // drain now and then so the sender waits on an empty pipeline
            add_op(op, $urandom, p, g, (made == 0) || ($urandom_range(0, 99) == 0));
            made++;
         end
      end

      reset <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // wait until every item is accepted and every response is back
      while (pending_ops.size() != 0 || staged || req_tvalid) @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_rsp.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/spq_pkg.sv
sv/spq_front.sv
sv/spq_back.sv
sv/sorted_priority_queue_core.sv
tb/sv/sorted_priority_queue_core_test.sv
